FILE: hdl/imh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imh_pkg
// Shared sizes, codes and word types of the indexed min-heap.
// ----------------------------------------------------------------------------
package imh_pkg;

  localparam int CAPACITY      = 1024;
  localparam int KEYS          = 4096;
  localparam int PRIORITY_BITS = 16;

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int KEY_W  = $clog2(KEYS);
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;
  localparam logic [1:0] OP_POP    = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_SLOT      = 3'd4;

  typedef struct packed {
    logic [1:0]               opcode;
    logic [KEY_W-1:0]         key;
    logic [PRIORITY_BITS-1:0] priority_req;
    logic [SLOT_W-1:0]        slot;
  } in_word_t;

  typedef struct packed {
    logic [2:0]               status;
    logic [SLOT_W-1:0]        found_slot;
    logic [KEY_W-1:0]         out_key;
    logic [PRIORITY_BITS-1:0] out_priority;
    logic [CNT_W-1:0]         count;
  } out_word_t;

  typedef struct packed {
    logic [KEY_W-1:0]         key;
    logic [PRIORITY_BITS-1:0] prio;
  } heap_item_t;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } map_entry_t;

endpackage
`default_nettype wire

FILE: hdl/indexed_min_heap.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_min_heap
// Binary min-heap of (key, priority) words with a key-to-slot position map.
// Insert, lookup, modify-at-slot and pop-minimum, one command at a time.
// ----------------------------------------------------------------------------
//
//  channel | ports                     | handshake
//  --------+---------------------------+----------------------------------
//  input   | start, busy, in_word      | taken on start && !busy
//  result  | out_valid, out_word       | one-cycle strobe, cannot stall
//
// Insert climbs level by level; modify climbs or walks down; pop walks
// down from the root. Refused commands, lookups and the pop of the only
// entry run no sift. Worst case at 1024 entries is a modify walking root
// to bottom. Sift speed is set by the heap RAM's single read port: a
// sift-down step reads left and right child back to back.
// Reset: after rst_n the position map is cleared one key a cycle, with
// busy high. The heap RAM is never cleared; only slots below the count
// are read.
// Stalls: none on the result side; busy holds off commands while a command
// or the map clear is in flight.
//
// The word being sifted rides in cur_*_r; each step moves one displaced
// neighbor into the hole and updates its map entry, and the final state
// drops the moving word into the hole.
// ----------------------------------------------------------------------------
module indexed_min_heap (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire imh_pkg::in_word_t  in_word,
  output logic                    out_valid,
  output imh_pkg::out_word_t      out_word
);
  import imh_pkg::*;

  // sequencer states
  localparam logic [3:0] S_CLR    = 4'd0;  // map clearing pass
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_LKUP   = 4'd2;  // map read returns
  localparam logic [3:0] S_MOD    = 4'd3;  // heap[slot] returns
  localparam logic [3:0] S_POP0   = 4'd4;  // root returns
  localparam logic [3:0] S_POP1   = 4'd5;  // last word returns
  localparam logic [3:0] S_UP     = 4'd6;  // issue parent read
  localparam logic [3:0] S_UPCMP  = 4'd7;  // parent returns
  localparam logic [3:0] S_DN     = 4'd8;  // issue left read
  localparam logic [3:0] S_DNL    = 4'd9;  // left returns
  localparam logic [3:0] S_DNR    = 4'd10; // right returns
  localparam logic [3:0] S_FIN    = 4'd11; // drop word into hole

  logic [3:0]               state_r, state_nxt;
  logic [KEY_W-1:0]         clr_r, clr_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]        at_r, at_nxt;
  logic [KEY_W-1:0]         cur_key_r, cur_key_nxt;
  logic [PRIORITY_BITS-1:0] cur_prio_r, cur_prio_nxt;
  logic                     moved_r, moved_nxt;
  heap_item_t               lch_r, lch_nxt;
  heap_item_t               top_r, top_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_word_t                out_word_r, out_word_nxt;

  // heap RAM port
  logic              h_we, h_re;
  logic [SLOT_W-1:0] h_waddr, h_raddr;
  heap_item_t        h_wdata, h_rdata;
  // map RAM port
  logic              m_we, m_re;
  logic [KEY_W-1:0]  m_waddr, m_raddr;
  map_entry_t        m_wdata, m_rdata;

  imh_ram #(.WIDTH($bits(heap_item_t)), .DEPTH(CAPACITY)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .re(h_re), .raddr(h_raddr), .rdata(h_rdata)
  );

  imh_ram #(.WIDTH($bits(map_entry_t)), .DEPTH(KEYS)) u_map (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .re(m_re), .raddr(m_raddr), .rdata(m_rdata)
  );

  // child / parent indices
  logic [CNT_W:0]    lidx, ridx;
  logic [SLOT_W-1:0] parent;
  heap_item_t        pick;
  logic [SLOT_W-1:0] pick_idx;

  assign lidx   = {1'b0, at_r, 1'b1};
  assign ridx   = lidx + (CNT_W+1)'(1);
  assign parent = (at_r - SLOT_W'(1)) >> 1;

  // child choice: ties go right
  always_comb begin
    if (state_r == S_DNR && lch_r.prio < h_rdata.prio) begin
      pick     = lch_r;
      pick_idx = lidx[SLOT_W-1:0];
    end else if (state_r == S_DNR) begin
      pick     = h_rdata;
      pick_idx = ridx[SLOT_W-1:0];
    end else begin
      pick     = h_rdata;
      pick_idx = lidx[SLOT_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cnt_nxt       = cnt_r;
    at_nxt        = at_r;
    cur_key_nxt   = cur_key_r;
    cur_prio_nxt  = cur_prio_r;
    moved_nxt     = moved_r;
    lch_nxt       = lch_r;
    top_nxt       = top_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    h_we = 1'b0; h_waddr = at_r; h_wdata = pick;
    h_re = 1'b0; h_raddr = at_r;
    m_we = 1'b0; m_waddr = pick.key; m_wdata = '{valid: 1'b1, slot: at_r};
    m_re = 1'b0; m_raddr = in_word.key;

    case (state_r)
      S_CLR: begin
        m_we    = 1'b1;
        m_waddr = clr_r;
        m_wdata = '0;
        clr_nxt = clr_r + KEY_W'(1);
        if (clr_r == KEY_W'(KEYS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          top_nxt                   = '0;
          out_word_nxt              = '0;
          out_word_nxt.count        = cnt_r;
          case (in_word.opcode)
            OP_INSERT: begin
              if (cnt_r == CNT_W'(CAPACITY)) begin
                out_word_nxt.status = ST_FULL;
                out_valid_nxt       = 1'b1;
              end else begin
                cur_key_nxt  = in_word.key;
                cur_prio_nxt = in_word.priority_req;
                at_nxt       = cnt_r[SLOT_W-1:0];
                cnt_nxt      = cnt_r + CNT_W'(1);
                moved_nxt    = 1'b1;
                state_nxt    = S_UP;
              end
            end
            OP_LOOKUP: begin
              m_re      = 1'b1;
              state_nxt = S_LKUP;
            end
            OP_MODIFY: begin
              if ({1'b0, in_word.slot} >= cnt_r) begin
                out_word_nxt.status = ST_SLOT;
                out_valid_nxt       = 1'b1;
              end else begin
                h_re         = 1'b1;
                h_raddr      = in_word.slot;
                at_nxt       = in_word.slot;
                cur_prio_nxt = in_word.priority_req;
                moved_nxt    = 1'b0;
                state_nxt    = S_MOD;
              end
            end
            OP_POP: begin
              if (cnt_r == '0) begin
                out_word_nxt.status = ST_EMPTY;
                out_valid_nxt       = 1'b1;
              end else begin
                h_re      = 1'b1;
                h_raddr   = '0;
                state_nxt = S_POP0;
              end
            end
            default: ;
          endcase
        end
      end
      S_LKUP: begin
        out_word_nxt.status     = m_rdata.valid ? ST_OK : ST_NOT_FOUND;
        out_word_nxt.found_slot = m_rdata.valid ? m_rdata.slot : '0;
        out_valid_nxt           = 1'b1;
        state_nxt               = S_IDLE;
      end
      S_MOD: begin
        cur_key_nxt = h_rdata.key;
        state_nxt   = (cur_prio_r < h_rdata.prio) ? S_UP : S_DN;
      end
      S_POP0: begin
        // removed key goes absent before any later placement
        top_nxt   = h_rdata;
        m_we      = 1'b1;
        m_waddr   = h_rdata.key;
        m_wdata   = '0;
        cnt_nxt   = cnt_r - CNT_W'(1);
        moved_nxt = 1'b1;
        at_nxt    = '0;
        if (cnt_r == CNT_W'(1)) begin
          out_word_nxt.status       = ST_OK;
          out_word_nxt.out_key      = h_rdata.key;
          out_word_nxt.out_priority = h_rdata.prio;
          out_word_nxt.count        = '0;
          out_valid_nxt             = 1'b1;
          state_nxt                 = S_IDLE;
        end else begin
          h_re      = 1'b1;
          h_raddr   = cnt_nxt[SLOT_W-1:0];
          state_nxt = S_POP1;
        end
      end
      S_POP1: begin
        cur_key_nxt  = h_rdata.key;
        cur_prio_nxt = h_rdata.prio;
        state_nxt    = S_DN;
      end
      S_UP: begin
        if (at_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          h_re      = 1'b1;
          h_raddr   = parent;
          state_nxt = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (cur_prio_r < h_rdata.prio) begin
          h_we      = 1'b1;
          h_wdata   = h_rdata;
          m_we      = 1'b1;
          m_waddr   = h_rdata.key;
          at_nxt    = parent;
          moved_nxt = 1'b1;
          state_nxt = S_UP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DN: begin
        if (lidx >= {1'b0, cnt_r}) begin
          state_nxt = S_FIN;
        end else begin
          h_re      = 1'b1;
          h_raddr   = lidx[SLOT_W-1:0];
          state_nxt = S_DNL;
        end
      end
      S_DNL, S_DNR: begin
        if (state_r == S_DNL && ridx < {1'b0, cnt_r}) begin
          lch_nxt   = h_rdata;
          h_re      = 1'b1;
          h_raddr   = ridx[SLOT_W-1:0];
          state_nxt = S_DNR;
        end else if (pick.prio < cur_prio_r) begin
          h_we      = 1'b1;
          m_we      = 1'b1;
          at_nxt    = pick_idx;
          moved_nxt = 1'b1;
          state_nxt = S_DN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        h_we    = 1'b1;
        h_wdata = '{key: cur_key_r, prio: cur_prio_r};
        m_we    = moved_r;
        m_waddr = cur_key_r;
        out_word_nxt.status       = ST_OK;
        out_word_nxt.out_key      = top_r.key;
        out_word_nxt.out_priority = top_r.prio;
        out_word_nxt.count        = cnt_r;
        out_valid_nxt             = 1'b1;
        state_nxt                 = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    at_r       <= at_nxt;
    cur_key_r  <= cur_key_nxt;
    cur_prio_r <= cur_prio_nxt;
    moved_r    <= moved_nxt;
    lch_r      <= lch_nxt;
    top_r      <= top_nxt;
    out_word_r <= out_word_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // count never passes capacity
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // heap writes stay inside the live region
  a_wr_live: assert property (@(posedge clk) disable iff (!rst_n)
    h_we |-> ({1'b0, h_waddr} < cnt_r))
    else $error("heap write beyond count");

  // no same-cycle read and write of one heap slot
  a_no_rw: assert property (@(posedge clk) disable iff (!rst_n)
    (h_we && h_re) |-> (h_waddr != h_raddr))
    else $error("heap read/write collision");

  // an accepted command either keeps the block busy or answers at once
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("command dropped");

endmodule
`default_nettype wire

FILE: hdl/imh_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imh_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/indexed_min_heap_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap_test
// Self-checking bench for the indexed min-heap: a queue-fed command driver,
// a result monitor, and a behavioral heap with position map that predicts
// every result word.
// ----------------------------------------------------------------------------
module indexed_min_heap_test;
  import imh_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_word_t   in_word;
  logic       out_valid;
  out_word_t  out_word;

  indexed_min_heap dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_word(in_word), .out_valid(out_valid), .out_word(out_word)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Behavioral heap: entries, key-to-slot map and fill count.
  heap_item_t             heap_mem [CAPACITY];
  logic [SLOT_W-1:0]      key_slot [KEYS];
  logic                   key_live [KEYS] = '{default: 1'b0};
  int unsigned            fill = 0;

  in_word_t  cmd_queue [$];
  out_word_t expected_words [$];
  int        errors = 0;
  int        gap_left;
  logic      accepted_last = 1'b0;
  int        est_fill;

  task automatic add_cmd(input in_word_t w);
    cmd_queue.insert(cmd_queue.size(), w);
  endtask

  function automatic void put_item(input int unsigned at, input heap_item_t it);
    heap_mem[at] = it;
    key_slot[it.key] = at[SLOT_W-1:0];
    key_live[it.key] = 1'b1;
  endfunction

  function automatic void swap_items(input int unsigned a, input int unsigned b);
    heap_item_t ta, tb;
    ta = heap_mem[a];
    tb = heap_mem[b];
    put_item(a, tb);
    put_item(b, ta);
  endfunction

  function automatic void climb(input int unsigned start_at);
    int unsigned at, up;
    at = start_at;
    while (at > 0) begin
      up = (at - 1) / 2;
      if (heap_mem[at].prio < heap_mem[up].prio) begin
        swap_items(at, up);
        at = up;
      end else begin
        break;
      end
    end
  endfunction

  function automatic void descend(input int unsigned start_at);
    int unsigned at, l, r, pick;
    at = start_at;
    forever begin
      l = 2 * at + 1;
      r = 2 * at + 2;
      if (l >= fill) break;
      if (r >= fill) pick = l;
      else pick = (heap_mem[l].prio < heap_mem[r].prio) ? l : r;
      if (heap_mem[pick].prio < heap_mem[at].prio) begin
        swap_items(at, pick);
        at = pick;
      end else begin
        break;
      end
    end
  endfunction

  // Apply one command to the behavioral heap and return the result word.
  function automatic out_word_t heap_apply(input in_word_t w);
    out_word_t  r;
    heap_item_t it;
    logic       go_up;
    r = '0;
    r.status = ST_OK;
    case (w.opcode)
      OP_INSERT: begin
        if (fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          it.key = w.key;
          it.prio = w.priority_req;
          put_item(fill, it);
          fill++;
          climb(fill - 1);
        end
      end
      OP_LOOKUP: begin
        if (key_live[w.key]) r.found_slot = key_slot[w.key];
        else r.status = ST_NOT_FOUND;
      end
      OP_MODIFY: begin
        if (w.slot >= fill) begin
          r.status = ST_SLOT;
        end else begin
          go_up = w.priority_req < heap_mem[w.slot].prio;
          heap_mem[w.slot].prio = w.priority_req;
          if (go_up) climb(w.slot);
          else descend(w.slot);
        end
      end
      default: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.out_key = heap_mem[0].key;
          r.out_priority = heap_mem[0].prio;
          key_live[heap_mem[0].key] = 1'b0;
          fill--;
          if (fill > 0) begin
            put_item(0, heap_mem[fill]);
            descend(0);
          end
        end
      end
    endcase
    r.count = fill[CNT_W-1:0];
    return r;
  endfunction

  function automatic in_word_t make_cmd(input logic [1:0] op, input int k,
                                        input int p, input int s);
    in_word_t w;
    w.opcode = op;
    w.key = k[KEY_W-1:0];
    w.priority_req = p[PRIORITY_BITS-1:0];
    w.slot = s[SLOT_W-1:0];
    return w;
  endfunction

  // Random gap: mostly none or short, occasionally long.
  function automatic int pick_gap();
    int d;
    d = $urandom_range(0, 99);
    if (d < 50) return 0;
    if (d < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic check_word(input out_word_t e, input out_word_t a);
    if (a.status !== e.status) begin
      $error("status expected %0d actual %0d", e.status, a.status); errors++;
    end
    if (a.found_slot !== e.found_slot) begin
      $error("found_slot expected %0d actual %0d", e.found_slot, a.found_slot);
      errors++;
    end
    if (a.out_key !== e.out_key) begin
      $error("out_key expected %0d actual %0d", e.out_key, a.out_key); errors++;
    end
    if (a.out_priority !== e.out_priority) begin
      $error("out_priority expected %0d actual %0d", e.out_priority,
             a.out_priority);
      errors++;
    end
    if (a.count !== e.count) begin
      $error("count expected %0d actual %0d", e.count, a.count); errors++;
    end
  endtask

  // Driver: a word stays on the bus with start high until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      start   <= 1'b0;
      in_word <= '0;
      gap_left = 0;
    end else if (start && !accepted_last) begin
      // still waiting for busy to drop
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (cmd_queue.size() > 0) begin
      in_word <= cmd_queue.pop_front();
      start   <= 1'b1;
      gap_left = pick_gap();
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: checks result words and predicts at acceptance.
  always @(posedge clk) begin
    accepted_last <= 1'b0;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          check_word(expected_words.pop_front(), out_word);
        end
      end
      if (start && !busy) begin
        expected_words.insert(expected_words.size(), heap_apply(in_word));
        accepted_last <= 1'b1;
      end
    end
  end

  // Stimulus. Tracks a rough fill so random ops hover over interesting sizes.
  task automatic queue_random(input int n, input int bias_insert);
    int d;
    for (int i = 0; i < n; i++) begin
      d = $urandom_range(0, 99);
      if (d < bias_insert) begin
        add_cmd(make_cmd(OP_INSERT, $urandom_range(0, 4095),
                         $urandom_range(0, 65535), $urandom_range(0, 1023)));
        if (est_fill < CAPACITY) est_fill++;
      end else if (d < bias_insert + 15) begin
        add_cmd(make_cmd(OP_LOOKUP, $urandom_range(0, 4095), $urandom, $urandom));
      end else if (d < bias_insert + 40) begin
        add_cmd(make_cmd(OP_MODIFY, $urandom, $urandom_range(0, 65535),
          ($urandom_range(0, 9) == 0 || est_fill == 0) ? $urandom_range(0, 1023)
                                                       : $urandom_range(0, est_fill - 1)));
      end else begin
        add_cmd(make_cmd(OP_POP, $urandom, $urandom, $urandom));
        if (est_fill > 0) est_fill--;
      end
    end
  endtask

  initial begin
    est_fill = 0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Directed: empty pop, bad slot, absent lookup, extremes, ties.
    add_cmd(make_cmd(OP_POP, 0, 0, 0));
    add_cmd(make_cmd(OP_MODIFY, 0, 5, 0));
    add_cmd(make_cmd(OP_LOOKUP, 4095, 0, 0));
    add_cmd(make_cmd(OP_INSERT, 4095, 65535, 1023));
    add_cmd(make_cmd(OP_INSERT, 0, 0, 0));
    add_cmd(make_cmd(OP_INSERT, 7, 100, 0));
    add_cmd(make_cmd(OP_INSERT, 8, 100, 0));
    add_cmd(make_cmd(OP_INSERT, 7, 50, 0));    // duplicate key
    add_cmd(make_cmd(OP_LOOKUP, 7, 0, 0));
    add_cmd(make_cmd(OP_LOOKUP, 4095, 0, 0));
    add_cmd(make_cmd(OP_MODIFY, 0, 65535, 0));   // sift down
    add_cmd(make_cmd(OP_MODIFY, 0, 0, 4));       // sift up
    add_cmd(make_cmd(OP_MODIFY, 0, 1, 1023));    // out of range
    add_cmd(make_cmd(OP_MODIFY, 0, 100, 2));     // equal priority
    for (int i = 0; i < 6; i++) add_cmd(make_cmd(OP_POP, 0, 0, 0));
    add_cmd(make_cmd(OP_LOOKUP, 0, 0, 0));
    est_fill = 0;

    // Random phases: growth, churn, drain.
    queue_random(300, 60);
    queue_random(250, 30);
    queue_random(280, 15);

    while (cmd_queue.size() > 0 || start) @(posedge clk);
    while (expected_words.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog: reset clear plus ~850 words at worst latency and long gaps
  // needs under 2 ms.
  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/imh_pkg.sv
hdl/imh_ram.sv
hdl/indexed_min_heap.sv
tb/sv/indexed_min_heap_test.sv
